// File: rtl/core/pixel_neighbour_weight_mask_macros.svh
// Assertion helpers for the checker of this block.
`ifndef PIXEL_NEIGHBOUR_WEIGHT_MASK_MACROS_SVH
`define PIXEL_NEIGHBOUR_WEIGHT_MASK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNWM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNWM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pnwm_pkg.sv
package pnwm_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 256;
    localparam int RESET_DIM       = 32;

    localparam int PIXEL_W     = 8;
    localparam int CODE_W      = 2;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int FLAG_W      = 2;

    localparam logic [PIXEL_W-1:0] PIXEL_FULL = 8'hFF;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS    = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        CODE_ISOLATED = 2'd0,
        CODE_DIAG     = 2'd1,
        CODE_EDGE     = 2'd2,
        CODE_FULL     = 2'd3
    } code_t;

    // Per-pixel flags kept in the window: saturated value and nonzero value.
    typedef struct packed {
        logic full;
        logic nonzero;
    } flags_t;

    // Control carried with an item from acceptance into the window stage.
    typedef struct packed {
        logic   emit;
        logic   frame_end;
        logic   top;
        logic   bottom;
        logic   left;
        logic   right;
        flags_t cur;
    } s1_ctl_t;

    function automatic code_t classify(input logic center_full, input logic edge_any,
                                       input logic diag_any);
        code_t code;
        if (center_full) begin
            code = CODE_FULL;
        end else if (edge_any) begin
            code = CODE_EDGE;
        end else if (diag_any) begin
            code = CODE_DIAG;
        end else begin
            code = CODE_ISOLATED;
        end
        return code;
    endfunction

endpackage

// File: rtl/core/pnwm_line_buf.sv
// One-row line buffer with a registered read port. A read and a write to the same
// address in the same cycle return the data being written.
module pnwm_line_buf #(
    parameter int DEPTH = pnwm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic [2*pnwm_pkg::FLAG_W-1:0]   wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic [2*pnwm_pkg::FLAG_W-1:0]   rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [2*pnwm_pkg::FLAG_W-1:0] mem [DEPTH];
    logic [2*pnwm_pkg::FLAG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/pixel_neighbour_weight_mask.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata = pixel_value, s_tuser = mode
// m_        out        m_tvalid / m_tready  m_tdata = weight_code, m_tlast = frame_end
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction is accepted per clock unless a stalled result holds s_tready low;
// the code released by a transaction passes through the registered line buffer read
// and the window stage, then the result register.
// Reset is synchronous and active low; the line buffer and window taps are not
// cleared, since every tap outside the frame is masked to zero.
// A stalled result holds a code-releasing item in the window stage, which holds s_tready low.

module pixel_neighbour_weight_mask #(
    parameter int MAX_COLUMNS = pnwm_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = pnwm_pkg::MAX_ROWS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pnwm_pkg::PIXEL_W-1:0]        s_tdata,    // [7:0] pixel_value
    input  logic [0:0]                          s_tuser,    // [0] mode

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pnwm_pkg::M_TDATA_W-1:0]      m_tdata,    // [1:0] weight_code, rest zero
    output logic                                m_tlast,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pnwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pnwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Column address, column count, row count and arrival row widths. The arrival
    // row runs up to two past the last row while flush transactions drain the window.
    localparam int AW  = $clog2(MAX_COLUMNS);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int ARW = $clog2(MAX_ROWS + 2);
    localparam int XCW = (CW > pnwm_pkg::CFG_DATA_W) ? CW : pnwm_pkg::CFG_DATA_W;
    localparam int XRW = (RW > pnwm_pkg::CFG_DATA_W) ? RW : pnwm_pkg::CFG_DATA_W;
    localparam int RESET_COLS = (pnwm_pkg::RESET_DIM < MAX_COLUMNS) ?
                                pnwm_pkg::RESET_DIM : MAX_COLUMNS;
    localparam int RESET_ROWS = (pnwm_pkg::RESET_DIM < MAX_ROWS) ?
                                pnwm_pkg::RESET_DIM : MAX_ROWS;
    localparam int FW = pnwm_pkg::FLAG_W;

    // Frame geometry registers.
    logic [CW-1:0]  cols_reg, cols_next, cols_clamp;
    logic [RW-1:0]  rows_reg, rows_next, rows_clamp;
    logic [XCW-1:0] cfg_ext_c;
    logic [XRW-1:0] cfg_ext_r;
    logic           cfg_wr;

    // Raster position of the next arriving transaction and of the next code out.
    logic [AW-1:0]  arr_col_reg, arr_col_next;
    logic [ARW-1:0] arr_row_reg, arr_row_next;
    logic [AW-1:0]  emit_col_reg, emit_col_next;
    logic [RW-1:0]  emit_row_reg, emit_row_next;

    // Acceptance-side decode.
    logic               s_acc;
    logic               past_end;
    logic               ignore;
    logic               arr_last_col;
    logic               emit_last_col;
    logic               emit_last_row;
    pnwm_pkg::s1_ctl_t  s0_ctl;

    // Window stage.
    logic               s1_valid_reg, s1_valid_next;
    pnwm_pkg::s1_ctl_t  s1_ctl_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_fire;
    logic               out_free;

    // Window taps: b* are the row below, m* the pixel's own row, t* the row above.
    logic [2*FW-1:0]    lb_rd_data;
    pnwm_pkg::flags_t   a1, a2;
    pnwm_pkg::flags_t   b1_reg, b2_reg, m1_reg, m2_reg, t1_reg, t2_reg;
    logic               edge_any, diag_any;
    pnwm_pkg::code_t    code;

    // Result register.
    logic               m_valid_reg, m_valid_next;
    pnwm_pkg::code_t    m_code_reg;
    logic               m_last_reg;

    // ---------------------------------------------------------------------------
    // Configuration. A write takes effect at once and restarts the frame; values
    // are clamped to the supported range, with zero taken as one.
    // ---------------------------------------------------------------------------
    assign cfg_ready = aresetn;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign cfg_ext_c = XCW'(cfg_data);
    assign cfg_ext_r = XRW'(cfg_data);

    always_comb begin
        if (cfg_data == '0) begin
            cols_clamp = CW'(1);
        end else if (cfg_ext_c > XCW'(MAX_COLUMNS)) begin
            cols_clamp = CW'(MAX_COLUMNS);
        end else begin
            cols_clamp = CW'(cfg_ext_c);
        end
        if (cfg_data == '0) begin
            rows_clamp = RW'(1);
        end else if (cfg_ext_r > XRW'(MAX_ROWS)) begin
            rows_clamp = RW'(MAX_ROWS);
        end else begin
            rows_clamp = RW'(cfg_ext_r);
        end
    end

    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_wr && (cfg_index == pnwm_pkg::REG_FRAME_COLUMNS)) begin
            cols_next = cols_clamp;
        end
        if (cfg_wr && (cfg_index == pnwm_pkg::REG_FRAME_ROWS)) begin
            rows_next = rows_clamp;
        end
    end

    // ---------------------------------------------------------------------------
    // Acceptance. The position counters decide on the spot whether the transaction
    // releases a code, whether that code closes the frame, and which neighbours of
    // the released pixel lie inside the frame.
    // ---------------------------------------------------------------------------
    assign s_acc    = s_tvalid & s_tready;
    assign past_end = arr_row_reg >= ARW'(rows_reg);
    // A flush transaction before the final pixel has arrived does nothing.
    assign ignore   = (s_tuser[0] == pnwm_pkg::MODE_FLUSH) && !past_end;

    assign arr_last_col  = (CW'(arr_col_reg) + CW'(1)) == cols_reg;
    assign emit_last_col = (CW'(emit_col_reg) + CW'(1)) == cols_reg;
    assign emit_last_row = (emit_row_reg + RW'(1)) == rows_reg;

    always_comb begin
        // A code is due once one full row plus one pixel has arrived.
        s0_ctl.emit      = (arr_row_reg >= ARW'(2)) ||
                           ((arr_row_reg == ARW'(1)) && (arr_col_reg != '0));
        s0_ctl.frame_end = s0_ctl.emit && emit_last_row && emit_last_col;
        s0_ctl.top       = emit_row_reg != '0;
        s0_ctl.bottom    = !emit_last_row;
        s0_ctl.left      = emit_col_reg != '0;
        s0_ctl.right     = !emit_last_col;
        // Pixels past the end of the frame, flush or late, enter as zero.
        s0_ctl.cur.nonzero = !past_end && (s_tdata != '0);
        s0_ctl.cur.full    = !past_end && (s_tdata == pnwm_pkg::PIXEL_FULL);
    end

    always_comb begin
        arr_col_next  = arr_col_reg;
        arr_row_next  = arr_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        if (cfg_wr) begin
            arr_col_next  = '0;
            arr_row_next  = '0;
            emit_col_next = '0;
            emit_row_next = '0;
        end else if (s_acc && !ignore) begin
            if (s0_ctl.frame_end) begin
                // The last code of the frame restarts the raster for the next frame.
                arr_col_next  = '0;
                arr_row_next  = '0;
                emit_col_next = '0;
                emit_row_next = '0;
            end else begin
                if (arr_last_col) begin
                    arr_col_next = '0;
                    arr_row_next = arr_row_reg + ARW'(1);
                end else begin
                    arr_col_next = arr_col_reg + AW'(1);
                end
                if (s0_ctl.emit) begin
                    if (emit_last_col) begin
                        emit_col_next = '0;
                        emit_row_next = emit_row_reg + RW'(1);
                    end else begin
                        emit_col_next = emit_col_reg + AW'(1);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Window stage. The line buffer holds, per column, the flags of the two rows
    // above the arriving pixel; short shift registers supply the columns to the left.
    // ---------------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_ctl_reg.emit || out_free);
    assign s_tready = aresetn && (!s1_valid_reg || s1_fire);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_acc && !ignore) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    pnwm_line_buf #(
        .DEPTH   (MAX_COLUMNS)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data ({lb_rd_data[FW-1:0], s1_ctl_reg.cur}),
        .rd_en   (s_acc && !ignore),
        .rd_addr (arr_col_reg),
        .rd_data (lb_rd_data)
    );

    assign a1 = pnwm_pkg::flags_t'(lb_rd_data[FW-1:0]);
    assign a2 = pnwm_pkg::flags_t'(lb_rd_data[2*FW-1:FW]);

    // The released pixel is the center m1; neighbours outside the frame are masked.
    always_comb begin
        edge_any = (s1_ctl_reg.top    && t1_reg.nonzero) ||
                   (s1_ctl_reg.bottom && b1_reg.nonzero) ||
                   (s1_ctl_reg.left   && m2_reg.nonzero) ||
                   (s1_ctl_reg.right  && a1.nonzero);
        diag_any = (s1_ctl_reg.top    && s1_ctl_reg.left  && t2_reg.nonzero) ||
                   (s1_ctl_reg.top    && s1_ctl_reg.right && a2.nonzero) ||
                   (s1_ctl_reg.bottom && s1_ctl_reg.left  && b2_reg.nonzero) ||
                   (s1_ctl_reg.bottom && s1_ctl_reg.right && s1_ctl_reg.cur.nonzero);
        code     = pnwm_pkg::classify(m1_reg.full, edge_any, diag_any);
    end

    // ---------------------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_fire && s1_ctl_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pnwm_pkg::M_TDATA_W'(m_code_reg);
    assign m_tlast  = m_last_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg     <= CW'(RESET_COLS);
            rows_reg     <= RW'(RESET_ROWS);
            arr_col_reg  <= '0;
            arr_row_reg  <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            arr_col_reg  <= arr_col_next;
            arr_row_reg  <= arr_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_acc && !ignore) begin
            s1_ctl_reg  <= s0_ctl;
            s1_addr_reg <= arr_col_reg;
        end
        if (s1_fire) begin
            b1_reg <= s1_ctl_reg.cur;
            b2_reg <= b1_reg;
            m1_reg <= a1;
            m2_reg <= m1_reg;
            t1_reg <= a2;
            t2_reg <= t1_reg;
        end
        if (s1_fire && s1_ctl_reg.emit) begin
            m_code_reg <= code;
            m_last_reg <= s1_ctl_reg.frame_end;
        end
    end

endmodule

// File: rtl/core/pnwm_checker.sv
`include "pixel_neighbour_weight_mask_macros.svh"

module pnwm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [pnwm_pkg::PIXEL_W-1:0]        s_tdata,
    input logic [0:0]                          s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [pnwm_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic                                m_tlast,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [pnwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input logic [pnwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // A stalled result keeps its code and frame marker.
    `PNWM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // Only the weight code occupies the result data; the padding stays zero.
    `PNWM_ASSERT_NOW(a_out_pad, aclk, aresetn, m_tvalid, m_tdata[pnwm_pkg::M_TDATA_W-1:pnwm_pkg::CODE_W] == '0, "result padding not zero")

    // A result leaving an empty output comes from an accepted input transaction that passed the window stage.
    `PNWM_ASSERT_NOW(a_out_source, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without a matching input transaction")

    // Reset empties the result register.
    `PNWM_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind pixel_neighbour_weight_mask pnwm_checker u_pnwm_checker (.*);
